@@ design/wat_pkg.sv @@
// ----------------------------------------------------------------------------
// Window address translator package
// Shared types and constants for the controller and the datapath.
// ----------------------------------------------------------------------------
package wat_pkg;

  // Beat widths on the stream ports.
  localparam int IN_DATA_W  = 200;
  localparam int OUT_DATA_W = 40;
  localparam int FIELD_W    = 32;
  localparam int IDX_W      = 3;
  localparam int STATUS_W   = 2;

  // Configuration port.
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_DEVICE_SIZE  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_COUNT = 1'b1;
  localparam int WIN_CNT_W = 4;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_OUT_DEVICE = 2'd1,
    ST_NO_WINDOW  = 2'd2,
    ST_OUT_TARGET = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEARCH,
    S_REBASE,
    S_TARGET,
    S_FINISH
  } fsm_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;
    logic    mem_wr;
    logic    rd_en;
    logic    rd_clr;
    logic    rebase_en;
    logic    res_set;
    status_t res_code;
    logic    out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_load;
    logic dev_ok;
    logic cap_zero;
    logic win_hit;
    logic ptr_last;
    logic tgt_ok;
    logic out_free;
  } sts_t;

endpackage

@@ design/wat_ctrl.sv @@
// ----------------------------------------------------------------------------
// Window address translator controller
// Sequences one item at a time: dispatch, window search, rebase, target check.
// ----------------------------------------------------------------------------
module wat_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  wat_pkg::sts_t sts,
  output wat_pkg::cmd_t cmd
);
  import wat_pkg::*;

  fsm_state_t state_r;
  fsm_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        // Loads complete here; translations are first checked against the device.
        if (sts.is_load) begin
          cmd.mem_wr   = 1'b1;
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_OK;
          state_nxt    = S_FINISH;
        end else if (!sts.dev_ok) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_OUT_DEVICE;
          state_nxt    = S_FINISH;
        end else if (sts.cap_zero) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_NO_WINDOW;
          state_nxt    = S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_clr = 1'b1;
          state_nxt  = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (sts.win_hit) begin
          state_nxt = S_REBASE;
        end else if (sts.ptr_last) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_NO_WINDOW;
          state_nxt    = S_FINISH;
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      S_REBASE: begin
        cmd.rebase_en = 1'b1;
        state_nxt     = S_TARGET;
      end
      S_TARGET: begin
        cmd.res_set  = 1'b1;
        cmd.res_code = sts.tgt_ok ? ST_OK : ST_OUT_TARGET;
        state_nxt    = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/wat_datapath.sv @@
// ----------------------------------------------------------------------------
// Window address translator datapath
// Configuration registers, window table memory, span checks and result register.
// ----------------------------------------------------------------------------
module wat_datapath #(
  parameter int MAX_WINDOWS = 8,
  parameter int ADDR_BITS   = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [wat_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [wat_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [wat_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [wat_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  wat_pkg::cmd_t                    cmd,
  output wat_pkg::sts_t                    sts
);
  import wat_pkg::*;

  localparam int AW = ADDR_BITS;
  localparam int IW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int CW = (IW + 1 > WIN_CNT_W) ? IW + 1 : WIN_CNT_W;

  // Fits a 32-bit field into the address width, truncating or zero-extending.
  function automatic logic [AW-1:0] to_aw(input logic [FIELD_W-1:0] v);
    logic [AW+FIELD_W-1:0] e;
    e = {{AW{1'b0}}, v};
    return e[AW-1:0];
  endfunction

  // Configuration registers.
  logic [FIELD_W-1:0]   dev_size_r;
  logic [WIN_CNT_W-1:0] win_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_size_r <= '0;
      win_cnt_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_DEVICE_SIZE:  dev_size_r <= cfg_wdata;
        REG_WINDOW_COUNT: win_cnt_r  <= cfg_wdata[WIN_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured item.
  logic          mode_r;
  logic [IDX_W-1:0] idx_r;
  logic [AW-1:0] off_r;
  logic [AW-1:0] len_r;
  logic [AW-1:0] ld_start_r;
  logic [AW-1:0] ld_len_r;
  logic [AW-1:0] ld_base_r;
  logic [AW-1:0] ld_tlen_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r     <= in_tuser;
      idx_r      <= in_tdata[2:0];
      off_r      <= to_aw(in_tdata[34:3]);
      len_r      <= to_aw(in_tdata[66:35]);
      ld_start_r <= to_aw(in_tdata[98:67]);
      ld_len_r   <= to_aw(in_tdata[130:99]);
      ld_base_r  <= to_aw(in_tdata[162:131]);
      ld_tlen_r  <= to_aw(in_tdata[194:163]);
    end
  end

  // Window table: one entry holds start, length, target base and target length.
  logic [4*AW-1:0] win_mem [MAX_WINDOWS];
  logic [4*AW-1:0] rd_data_r;
  logic [IW-1:0]   ptr_r;
  logic [IW-1:0]   rd_addr;
  logic [IW+IDX_W-1:0] idx_ext;
  logic [IW-1:0]   wr_addr;
  logic            idx_ok;

  always_comb begin
    idx_ext = {{IW{1'b0}}, idx_r};
    wr_addr = idx_ext[IW-1:0];
    idx_ok  = (idx_ext < (IW + IDX_W)'(MAX_WINDOWS));
    rd_addr = cmd.rd_clr ? '0 : ptr_r + IW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr && idx_ok) begin
      win_mem[wr_addr] <= {ld_tlen_r, ld_base_r, ld_len_r, ld_start_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= win_mem[rd_addr];
      ptr_r     <= rd_addr;
    end
  end

  logic [AW-1:0] rs_start;
  logic [AW-1:0] rs_len;
  logic [AW-1:0] rs_base;
  logic [AW-1:0] rs_tlen;
  assign {rs_tlen, rs_base, rs_len, rs_start} = rd_data_r;

  // Span checks; all sums wrap at the address width.
  logic [AW-1:0] req_end;
  logic [AW-1:0] win_end;
  logic [AW-1:0] reb_end;
  logic [AW-1:0] tgt_end;
  logic [AW-1:0] rebased_r;
  logic [CW-1:0] cap;
  logic [CW-1:0] cnt_ext;

  always_comb begin
    req_end = off_r + len_r;
    win_end = rs_start + rs_len;
    reb_end = rebased_r + len_r;
    tgt_end = rs_base + rs_tlen;
    cnt_ext = CW'(win_cnt_r);
    cap     = (cnt_ext > CW'(MAX_WINDOWS)) ? CW'(MAX_WINDOWS) : cnt_ext;
  end

  always_ff @(posedge clk) begin
    if (cmd.rebase_en) begin
      rebased_r <= off_r - rs_start + rs_base;
    end
  end

  // Result code and output register.
  status_t res_code_r;
  logic    out_valid_r;
  status_t out_status_r;
  logic [IDX_W-1:0]   out_hit_r;
  logic [FIELD_W-1:0] out_root_r;
  logic [IW+IDX_W-1:0]    ptr_ext;
  logic [AW+FIELD_W-1:0]  root_ext;

  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_code_r <= cmd.res_code;
    end
  end

  always_comb begin
    ptr_ext  = {{IDX_W{1'b0}}, ptr_r};
    root_ext = {{FIELD_W{1'b0}}, rebased_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_code_r;
      out_hit_r    <= (!mode_r && (res_code_r == ST_OK || res_code_r == ST_OUT_TARGET))
                      ? ptr_ext[IDX_W-1:0] : '0;
      out_root_r   <= (!mode_r && res_code_r == ST_OK) ? root_ext[FIELD_W-1:0] : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_root_r, out_hit_r, out_status_r};

  always_comb begin
    sts.is_load  = mode_r;
    sts.dev_ok   = (req_end <= to_aw(dev_size_r)) && (req_end >= off_r);
    sts.cap_zero = (cap == '0);
    sts.win_hit  = (off_r >= rs_start) && (req_end <= win_end) && (req_end >= off_r);
    sts.ptr_last = ((CW'(ptr_r) + CW'(1)) >= cap);
    sts.tgt_ok   = (rebased_r >= rs_base) && (reb_end <= tgt_end) && (reb_end >= rebased_r);
    sts.out_free = !out_valid_r || out_tready;
  end

  // A failed device or window check never reports a window index.
  a_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_OUT_DEVICE || out_status_r == ST_NO_WINDOW)
    |-> out_hit_r == '0)
    else $error("hit index set on a failed lookup");

  // Only a successful translation carries a translated offset.
  a_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> out_root_r == '0)
    else $error("root offset set on a failed translation");

  // The result register is never overwritten while a beat is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over a pending beat");

  // The search never steps past the last window in use.
  a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en && !cmd.rd_clr |-> !sts.ptr_last)
    else $error("window search ran past the window count");

endmodule

@@ design/window_address_translator_core.sv @@
// ----------------------------------------------------------------------------
// Window address translator core
// Remaps device-space requests through a small table of address windows.
// ----------------------------------------------------------------------------
// Usage. Items arrive on the in_ stream. With in_tuser high a beat loads one
// window entry (span in device space, target base and length); with it low
// the beat is a translation request (offset, size). Every item yields exactly
// one beat on the out_ stream carrying a status code, the matching window
// index and the translated root offset. The device size and the number of
// windows searched are set through the cfg_ write port, by the user only while
// the block is idle (the block has no check for this); windows must be loaded
// before they are searched. Timing. One item is worked on at a time. A load,
// a translation that fails the device check and one with no window to search
// go straight from dispatch to the result register. Other translations read
// the window table from entry 0 until a match or the last window in use, since
// the table has a single read port and the search reads one entry per cycle;
// a match then passes the rebase and target steps. The result beat is
// presented in the next cycle, when the next item is accepted.
// Reset clears the controller, the result valid flag and both configuration
// registers; the window table is not cleared. When the receiver stalls the
// result beat holds in the output register, a new item may still be accepted
// and worked on, and the controller waits before loading the next result.
// ----------------------------------------------------------------------------
module window_address_translator_core #(
  parameter int MAX_WINDOWS = 8,
  parameter int ADDR_BITS   = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration: index 0 device size, index 1 number of windows searched.
  input  logic                            cfg_wr_en,
  input  logic [wat_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [wat_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // Request stream.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // in_tdata, from bit 0: entry_index[3], req_offset[32], req_size[32],
  // load_win_start[32], load_win_len[32], load_target_base[32],
  // load_target_len[32], five zero bits.
  input  logic [wat_pkg::IN_DATA_W-1:0]   in_tdata,
  // in_tuser: mode (0 translate, 1 load window).
  input  logic                            in_tuser,
  // Result stream.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_tdata, from bit 0: status[2], hit_index[3], root_offset[32],
  // three zero bits.
  output logic [wat_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import wat_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller owns the input handshake and the order of the steps.
  wat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the registers, the window table and the result beat.
  wat_datapath #(
    .MAX_WINDOWS (MAX_WINDOWS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
